[rtl/spq_pkg.sv]
// Package with the shared constants and record type of the stable priority queue.
`default_nettype none
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OCC_W    = 5;
    localparam int CNT_W    = ($clog2(CAPACITY + 1) > OCC_W) ? $clog2(CAPACITY + 1) : OCC_W;

    localparam int PRIO_W   = 2;
    localparam int AGE_W    = 7;
    localparam int TAG_W    = 64;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 80;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
        logic [PRIO_W-1:0] prio;
    } record_t;

endpackage
`default_nettype wire

[rtl/stable_priority_queue_top.sv]
// Top level of the stable priority queue: sequencer around a simple dual-port record memory.
`default_nettype none
// Stable priority queue of up to CAPACITY records held in service order in one
// record memory with one read and one write port. An item is taken only while the
// sequencer is idle. A dequeue on an empty queue, a refused enqueue and an enqueue
// into an empty queue go from acceptance straight to the done state; an enqueue
// moves each record of lower priority one place back, also when it goes to the
// front, and a dequeue returns the head and moves every other record one place
// forward. Records move one per cycle through the memory port. A result waits in
// the output register until taken; the next item is accepted meanwhile.
module stable_priority_queue_top
    import spq_pkg::*;
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // in_priority[1:0], in_age[8:2], in_tag[72:9], zero fill
    input  wire  [IN_DATA_W-1:0]         s_tdata,
    // operation[0]
    input  wire  [0:0]                   s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // out_priority[1:0], out_age[8:2], out_tag[72:9], occupancy[77:73], zero fill
    output logic [OUT_DATA_W-1:0]        m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]          m_tuser
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DEQ_RD   = 3'd1;
    localparam logic [2:0] ST_DEQ_WR   = 3'd2;
    localparam logic [2:0] ST_ENQ_RD   = 3'd3;
    localparam logic [2:0] ST_ENQ_CMP  = 3'd4;
    localparam logic [2:0] ST_ENQ_HEAD = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    record_t             mem [CAPACITY];
    record_t             rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    record_t             wr_data;

    logic [2:0]          state_reg, state_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    record_t             new_reg, new_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    record_t             res_rec_reg, res_rec_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    record_t             out_rec_reg;
    logic [OCC_W-1:0]    out_occ_reg;
    logic                out_load;

    record_t             in_rec;
    logic                in_accept;

    assign in_rec    = record_t'(s_tdata[TAG_W+AGE_W+PRIO_W-1:0]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        new_next        = new_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        rd_addr         = idx_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = new_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    new_next        = in_rec;
                    res_rec_next    = '0;
                    res_status_next = STATUS_DONE;
                    if (s_tuser[0] == OP_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STATUS_EMPTY;
                            state_next      = ST_DONE;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_DEQ_RD;
                        end
                    end
                    else if (count_reg >= CNT_W'(CAPACITY))
                    begin
                        res_status_next = STATUS_FULL;
                        state_next      = ST_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = in_rec;
                        count_next = count_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        idx_next   = ADDR_W'(count_reg - 1'b1);
                        state_next = ST_ENQ_RD;
                    end
                end
            end
            ST_DEQ_RD:
            begin
                rd_addr    = idx_reg;
                state_next = ST_DEQ_WR;
            end
            ST_DEQ_WR:
            begin
                rd_addr = idx_reg + 1'b1;
                if (idx_reg == '0)
                begin
                    res_rec_next = rd_data_reg;
                end
                else
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg - 1'b1;
                    wr_data = rd_data_reg;
                end
                if ((CNT_W'(idx_reg) + 1'b1) < count_reg)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_ENQ_RD:
            begin
                rd_addr    = idx_reg;
                state_next = ST_ENQ_CMP;
            end
            ST_ENQ_CMP:
            begin
                rd_addr = idx_reg - 1'b1;
                wr_en   = 1'b1;
                wr_addr = idx_reg + 1'b1;
                if (rd_data_reg.prio >= new_reg.prio)
                begin
                    wr_data    = new_reg;
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    wr_data = rd_data_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_ENQ_HEAD;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            ST_ENQ_HEAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = new_reg;
                count_next = count_reg + 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        new_reg        <= new_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_rec_reg    <= res_rec_reg;
            out_occ_reg    <= count_reg[OCC_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(OUT_DATA_W - OCC_W - TAG_W - AGE_W - PRIO_W){1'b0}},
                       out_occ_reg, out_rec_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("record count exceeds capacity");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_status_reg == STATUS_FULL)
            |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status while space is left");

    a_empty_only_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_status_reg == STATUS_EMPTY) |-> count_reg == '0)
        else $error("empty status while records are held");

    a_done_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && !m_tready) |=> state_reg == ST_DONE)
        else $error("result overwrote an untaken output");
`endif

endmodule
`default_nettype wire
